>>> rtl/core/grid_word_window_counter_top_assert.svh
// Assertion helpers shared by the grid word window counter modules.
`ifndef GRID_WORD_WINDOW_COUNTER_TOP_ASSERT_SVH
`define GRID_WORD_WINDOW_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GWWC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gwwc same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GWWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gwwc next-cycle check failed");

`endif

>>> rtl/core/gwwc_pkg.sv
package gwwc_pkg;

    localparam int MAX_WIDTH_DEF   = 256;
    localparam int MAX_HEIGHT_DEF  = 256;
    localparam int ROW_WIDTH_W     = 9;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 9'd140;
    localparam int WORD_W          = 18;
    localparam int CROSS_W         = 16;
    localparam logic [WORD_W-1:0]  WORD_MAX  = '1;
    localparam logic [CROSS_W-1:0] CROSS_MAX = '1;
    localparam int SYM_W           = 3;
    localparam int LINE_W          = 3 * SYM_W;

    typedef enum logic [SYM_W-1:0] {
        SYM_OTHER = 3'd0,
        SYM_X     = 3'd1,
        SYM_M     = 3'd2,
        SYM_A     = 3'd3,
        SYM_S     = 3'd4
    } t_sym;

    // One item on its way from the accept edge to the window stage.
    typedef struct packed {
        t_sym       code;
        logic       col_ge2;
        logic       col_ge3;
        logic       row_ge2;
        logic       row_ge3;
        logic [1:0] slot;
        logic       last;
    } t_s1;

    function automatic t_sym encode(input logic [7:0] b);
        t_sym s;
        case (b)
            8'h58:   s = SYM_X;
            8'h4D:   s = SYM_M;
            8'h41:   s = SYM_A;
            8'h53:   s = SYM_S;
            default: s = SYM_OTHER;
        endcase
        return s;
    endfunction

    function automatic t_sym line_code(input logic [LINE_W-1:0] w, input logic [1:0] idx);
        t_sym s;
        case (idx)
            2'd0:    s = t_sym'(w[0*SYM_W +: SYM_W]);
            2'd1:    s = t_sym'(w[1*SYM_W +: SYM_W]);
            2'd2:    s = t_sym'(w[2*SYM_W +: SYM_W]);
            default: s = SYM_OTHER;
        endcase
        return s;
    endfunction

    function automatic logic word4(input t_sym a, input t_sym b, input t_sym c, input t_sym d);
        return (a == SYM_X && b == SYM_M && c == SYM_A && d == SYM_S) ||
               (a == SYM_S && b == SYM_A && c == SYM_M && d == SYM_X);
    endfunction

    function automatic logic mas3(input t_sym a, input t_sym b, input t_sym c);
        return (b == SYM_A) &&
               ((a == SYM_M && c == SYM_S) || (a == SYM_S && c == SYM_M));
    endfunction

endpackage

>>> rtl/core/gwwc_line_mem.sv
module gwwc_line_mem #(
    parameter int DEPTH = gwwc_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [gwwc_pkg::LINE_W-1:0] i_wr_data,
    output logic [gwwc_pkg::LINE_W-1:0] o_rd_data
);

    logic [gwwc_pkg::LINE_W-1:0] r_mem [0:DEPTH-1];
    logic [gwwc_pkg::LINE_W-1:0] r_rd_data;
    logic [gwwc_pkg::LINE_W-1:0] r_fwd_data;
    logic                        r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // The array returns the old word when written and read at one edge: take the new one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule

>>> rtl/core/gwwc_window.sv
`include "grid_word_window_counter_top_assert.svh"

module gwwc_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  gwwc_pkg::t_s1                 i_item,
    input  logic [gwwc_pkg::LINE_W-1:0]   i_line,
    output logic [gwwc_pkg::WORD_W-1:0]   o_word_total,
    output logic [gwwc_pkg::CROSS_W-1:0]  o_cross_total
);

    gwwc_pkg::t_sym r_win [0:3][0:3];
    gwwc_pkg::t_sym n_win [0:3][0:3];
    logic [gwwc_pkg::WORD_W-1:0]  r_word;
    logic [gwwc_pkg::CROSS_W-1:0] r_cross;
    logic [gwwc_pkg::WORD_W-1:0]  n_word;
    logic [gwwc_pkg::CROSS_W-1:0] n_cross;
    logic [2:0]                   add;
    logic [gwwc_pkg::WORD_W:0]    word_sum;
    logic                         cross_hit;
    logic [1:0]                   slot1;
    logic [1:0]                   slot2;

    // Rows: 0 is three lines up, 3 is the line being received.
    always_comb begin
        slot1 = (i_item.slot == 2'd2) ? 2'd0 : i_item.slot + 2'd1;
        slot2 = (slot1 == 2'd2) ? 2'd0 : slot1 + 2'd1;
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 3; j++) begin
                n_win[k][j] = r_win[k][j+1];
            end
        end
        n_win[0][3] = gwwc_pkg::line_code(i_line, i_item.slot);
        n_win[1][3] = gwwc_pkg::line_code(i_line, slot1);
        n_win[2][3] = gwwc_pkg::line_code(i_line, slot2);
        n_win[3][3] = i_item.code;
    end

    always_comb begin
        add = 3'd0;
        if (i_item.col_ge3 &&
            gwwc_pkg::word4(n_win[3][0], n_win[3][1], n_win[3][2], n_win[3][3])) begin
            add = add + 3'd1;
        end
        if (i_item.row_ge3 &&
            gwwc_pkg::word4(n_win[0][3], n_win[1][3], n_win[2][3], n_win[3][3])) begin
            add = add + 3'd1;
        end
        if (i_item.col_ge3 && i_item.row_ge3) begin
            if (gwwc_pkg::word4(n_win[0][0], n_win[1][1], n_win[2][2], n_win[3][3])) begin
                add = add + 3'd1;
            end
            if (gwwc_pkg::word4(n_win[3][0], n_win[2][1], n_win[1][2], n_win[0][3])) begin
                add = add + 3'd1;
            end
        end
        word_sum = {1'b0, r_word} + {{(gwwc_pkg::WORD_W-2){1'b0}}, add};
        n_word   = (word_sum > {1'b0, gwwc_pkg::WORD_MAX}) ? gwwc_pkg::WORD_MAX
                                                           : word_sum[gwwc_pkg::WORD_W-1:0];
        cross_hit = i_item.col_ge2 && i_item.row_ge2 &&
                    gwwc_pkg::mas3(n_win[1][1], n_win[2][2], n_win[3][3]) &&
                    gwwc_pkg::mas3(n_win[3][1], n_win[2][2], n_win[1][3]);
        n_cross  = (cross_hit && r_cross != gwwc_pkg::CROSS_MAX) ? r_cross + 1'b1 : r_cross;
    end

    // Clear window and totals after the last item of a grid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 4; j++) begin
                    r_win[k][j] <= gwwc_pkg::SYM_OTHER;
                end
            end
            r_word  <= '0;
            r_cross <= '0;
        end else if (i_adv) begin
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 4; j++) begin
                    r_win[k][j] <= i_item.last ? gwwc_pkg::SYM_OTHER : n_win[k][j];
                end
            end
            r_word  <= i_item.last ? '0 : n_word;
            r_cross <= i_item.last ? '0 : n_cross;
        end
    end

    assign o_word_total  = n_word;
    assign o_cross_total = n_cross;

    `GWWC_ASSERT_NEXT(a_word_mono, i_clk, i_rst_n, i_adv && !i_item.last, r_word >= $past(r_word))
    `GWWC_ASSERT_NEXT(a_cross_mono, i_clk, i_rst_n, i_adv && !i_item.last, r_cross >= $past(r_cross))
    `GWWC_ASSERT_NEXT(a_totals_cleared, i_clk, i_rst_n, i_adv && i_item.last, r_word == '0 && r_cross == '0)

endmodule

>>> rtl/core/grid_word_window_counter_top.sv
// Streaming word-search counter for a character grid sent row by row, one byte per item.
// It takes one item every cycle: the line buffer is read at the accept edge and the 4x4
// window and running counts update as the window stage takes the item, and o_valid rises
// as it takes the item marked last. The line buffer is a single memory of MAX_WIDTH
// words, each holding the same column of the three previous rows; a write that meets a
// read of the same column is forwarded. Input stalls only while a second grid's last
// item waits behind a result not yet taken. No clearing pass runs after reset. The user
// must write row_width via i_cfg_we / i_cfg_wdata while the block is idle; unenforced.
`include "grid_word_window_counter_top_assert.svh"

module grid_word_window_counter_top #(
    parameter int MAX_WIDTH  = gwwc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gwwc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gwwc_pkg::ROW_WIDTH_W-1:0]   i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [7:0]                         i_ch,
    input  logic                               i_last,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [gwwc_pkg::WORD_W-1:0]        o_word_count,
    output logic [gwwc_pkg::CROSS_W-1:0]       o_cross_count
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int EW = (CW + 1 > gwwc_pkg::ROW_WIDTH_W) ? CW + 1 : gwwc_pkg::ROW_WIDTH_W;

    logic [gwwc_pkg::ROW_WIDTH_W-1:0] r_row_width;
    logic [CW-1:0]                    r_col;
    logic [RW-1:0]                    r_row;
    logic [1:0]                       r_slot;
    logic                             r_s1_valid;
    gwwc_pkg::t_s1                    r_s1;
    logic [CW-1:0]                    r_s1_addr;
    logic                             r_out_valid;
    logic [gwwc_pkg::WORD_W-1:0]      r_out_word;
    logic [gwwc_pkg::CROSS_W-1:0]     r_out_cross;

    logic [EW-1:0]                    rw_ext;
    logic [EW-1:0]                    wid;
    logic [EW-1:0]                    col_ext;
    logic [EW-1:0]                    col_eff_ext;
    logic [CW-1:0]                    col_eff;
    logic                             row_end;
    logic [1:0]                       slot_inc;
    logic                             acc;
    logic                             adv1;
    logic [gwwc_pkg::LINE_W-1:0]      line_rd;
    logic [gwwc_pkg::LINE_W-1:0]      line_wr;
    logic [gwwc_pkg::WORD_W-1:0]      word_total;
    logic [gwwc_pkg::CROSS_W-1:0]     cross_total;

    always_comb begin
        rw_ext = EW'(r_row_width);
        if (rw_ext == '0) begin
            wid = EW'(1);
        end else if (rw_ext > EW'(MAX_WIDTH)) begin
            wid = EW'(MAX_WIDTH);
        end else begin
            wid = rw_ext;
        end
        col_ext     = EW'(r_col);
        // A width shrunk under the current column ends the row here.
        col_eff_ext = (col_ext >= wid) ? wid - EW'(1) : col_ext;
        col_eff     = col_eff_ext[CW-1:0];
        row_end     = (col_eff_ext + EW'(1)) >= wid;
        slot_inc    = (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
    end

    // Hold the window stage only for a last item while the previous result is not yet taken.
    assign adv1    = r_s1_valid && !(r_s1.last && r_out_valid && i_stall);
    assign o_stall = r_s1_valid && !adv1;
    assign acc     = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= gwwc_pkg::ROW_WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_row_width <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= 2'd0;
        end else if (acc) begin
            if (i_last) begin
                r_col  <= '0;
                r_row  <= '0;
                r_slot <= 2'd0;
            end else if (row_end) begin
                r_col  <= '0;
                r_slot <= slot_inc;
                if (r_row < RW'(MAX_HEIGHT - 1)) begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= col_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (adv1) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1.code    <= gwwc_pkg::encode(i_ch);
            r_s1.col_ge2 <= col_eff >= CW'(2);
            r_s1.col_ge3 <= col_eff >= CW'(3);
            r_s1.row_ge2 <= r_row >= RW'(2);
            r_s1.row_ge3 <= r_row >= RW'(3);
            r_s1.slot    <= r_slot;
            r_s1.last    <= i_last;
            r_s1_addr    <= col_eff;
        end
    end

    // Replace the oldest row's code in this column with the new one.
    always_comb begin
        line_wr = line_rd;
        case (r_s1.slot)
            2'd0:    line_wr[0*gwwc_pkg::SYM_W +: gwwc_pkg::SYM_W] = r_s1.code;
            2'd1:    line_wr[1*gwwc_pkg::SYM_W +: gwwc_pkg::SYM_W] = r_s1.code;
            2'd2:    line_wr[2*gwwc_pkg::SYM_W +: gwwc_pkg::SYM_W] = r_s1.code;
            default: line_wr = line_rd;
        endcase
    end

    gwwc_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc),
        .i_rd_addr (col_eff),
        .i_wr_en   (adv1),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (line_wr),
        .o_rd_data (line_rd)
    );

    gwwc_window u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv1),
        .i_item        (r_s1),
        .i_line        (line_rd),
        .o_word_total  (word_total),
        .o_cross_total (cross_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv1 && r_s1.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && r_s1.last) begin
            r_out_word  <= word_total;
            r_out_cross <= cross_total;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_word_count  = r_out_word;
    assign o_cross_count = r_out_cross;

    `GWWC_ASSERT_IMP(a_block_only_last, i_clk, i_rst_n, r_s1_valid && o_stall, r_s1.last)
    `GWWC_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, adv1 && r_s1.last, o_valid)
    `GWWC_ASSERT_IMP(a_slot_range, i_clk, i_rst_n, r_s1_valid, r_slot != 2'd3 && r_s1.slot != 2'd3)
    `GWWC_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, acc && i_last, r_col == '0 && r_slot == 2'd0)

endmodule

>>> sim/grid_word_window_counter_top_tb.sv
`timescale 1ns / 1ps

module grid_word_window_counter_top_tb;

    localparam int unsigned MAX_W = gwwc_pkg::MAX_WIDTH_DEF;
    localparam int unsigned MAX_H = gwwc_pkg::MAX_HEIGHT_DEF;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned ITEM_GOAL = 1300;
    localparam int unsigned QUIET_AFTER = 1100;
    localparam int unsigned GRID_CAP = 48;

    localparam logic [7:0] CH_X   = 8'h58;
    localparam logic [7:0] CH_M   = 8'h4D;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_S   = 8'h53;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [31:0] WORD_SEQ = {CH_S, CH_A, CH_M, CH_X};

    typedef logic [gwwc_pkg::ROW_WIDTH_W-1:0] t_width;

    typedef struct packed {
        logic [gwwc_pkg::WORD_W-1:0]  words;
        logic [gwwc_pkg::CROSS_W-1:0] crosses;
    } t_tally;

    typedef struct packed {
        bit     typed;
        t_tally want;
    } t_note;

    typedef struct packed {
        bit         set_w;
        t_width     w;
        logic [7:0] ch;
        bit         last;
        bit         typed;
        t_tally     want;
    } t_vec;

    localparam int DIR_N = 24;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    t_width                           i_cfg_wdata;
    logic                             i_valid;
    logic                             o_stall;
    logic [7:0]                       i_ch;
    logic                             i_last;
    logic                             o_valid;
    logic                             i_stall;
    logic [gwwc_pkg::WORD_W-1:0]      o_word_count;
    logic [gwwc_pkg::CROSS_W-1:0]     o_cross_count;

    grid_word_window_counter_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_word_count  (o_word_count),
        .o_cross_count (o_cross_count)
    );

    // Directed grids: a lone X at the reset width, vertical word at width zero, backward row
    // word at width 511, a single cross at width 3, forward row word at width 256.
    t_vec dir_tab [DIR_N] = '{
        '{1'b0, 9'd0,   CH_X,   1'b1, 1'b1, '{18'd0, 16'd0}},
        '{1'b1, 9'd0,   CH_X,   1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_M,   1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_A,   1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_S,   1'b1, 1'b1, '{18'd1, 16'd0}},
        '{1'b1, 9'd511, 8'h00,  1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   8'hFF,  1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_S,   1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_A,   1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_M,   1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_X,   1'b1, 1'b1, '{18'd1, 16'd0}},
        '{1'b1, 9'd3,   CH_M,   1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_DOT, 1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_S,   1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_DOT, 1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_A,   1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_DOT, 1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_M,   1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_DOT, 1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_S,   1'b1, 1'b1, '{18'd0, 16'd1}},
        '{1'b1, 9'd256, CH_X,   1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_M,   1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_A,   1'b0, 1'b0, '{18'd0, 16'd0}},
        '{1'b0, 9'd0,   CH_S,   1'b1, 1'b1, '{18'd1, 16'd0}}
    };

    // Shadow of the block's state
    t_width         width_cfg = gwwc_pkg::ROW_WIDTH_RESET;
    gwwc_pkg::t_sym prior_rows [3][MAX_W];
    gwwc_pkg::t_sym win_sym [16];
    int unsigned    col_pos = 0;
    int unsigned    row_pos = 0;
    int unsigned    row_slot = 0;
    int unsigned    word_sum = 0;
    int unsigned    cross_sum = 0;

    t_note  note_q [$];
    t_tally tally_q [$];

    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned items_sent = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    function automatic gwwc_pkg::t_sym sym_of(input logic [7:0] b);
        case (b)
            CH_X:    return gwwc_pkg::SYM_X;
            CH_M:    return gwwc_pkg::SYM_M;
            CH_A:    return gwwc_pkg::SYM_A;
            CH_S:    return gwwc_pkg::SYM_S;
            default: return gwwc_pkg::SYM_OTHER;
        endcase
    endfunction

    function automatic int unsigned xmas_line(input gwwc_pkg::t_sym a, input gwwc_pkg::t_sym b,
                                              input gwwc_pkg::t_sym c, input gwwc_pkg::t_sym d);
        if (a == gwwc_pkg::SYM_X && b == gwwc_pkg::SYM_M &&
            c == gwwc_pkg::SYM_A && d == gwwc_pkg::SYM_S) return 1;
        if (a == gwwc_pkg::SYM_S && b == gwwc_pkg::SYM_A &&
            c == gwwc_pkg::SYM_M && d == gwwc_pkg::SYM_X) return 1;
        return 0;
    endfunction

    function automatic bit mas_diag(input gwwc_pkg::t_sym a, input gwwc_pkg::t_sym b,
                                    input gwwc_pkg::t_sym c);
        return b == gwwc_pkg::SYM_A &&
               ((a == gwwc_pkg::SYM_M && c == gwwc_pkg::SYM_S) ||
                (a == gwwc_pkg::SYM_S && c == gwwc_pkg::SYM_M));
    endfunction

    function automatic int unsigned eff_width(input t_width w);
        if (w == 0) return 1;
        if (w > MAX_W) return MAX_W;
        return w;
    endfunction

    // Advance the shadow grid by one character; report the tallies on the last one.
    function automatic void grid_scan_step(input logic [7:0] ch, input logic last,
                                           output bit done, output t_tally tally);
        int unsigned w, c, s, add, k, j;
        w = eff_width(width_cfg);
        c = (col_pos >= w) ? w - 1 : col_pos;
        s = row_slot;
        for (k = 0; k < 4; k++)
            for (j = 0; j < 3; j++)
                win_sym[k*4 + j] = win_sym[k*4 + j + 1];
        win_sym[3]  = prior_rows[s][c];
        win_sym[7]  = prior_rows[(s + 1) % 3][c];
        win_sym[11] = prior_rows[(s + 2) % 3][c];
        win_sym[15] = sym_of(ch);
        prior_rows[s][c] = win_sym[15];

        add = 0;
        if (c >= 3)
            add += xmas_line(win_sym[12], win_sym[13], win_sym[14], win_sym[15]);
        if (row_pos >= 3)
            add += xmas_line(win_sym[3], win_sym[7], win_sym[11], win_sym[15]);
        if (c >= 3 && row_pos >= 3) begin
            add += xmas_line(win_sym[0], win_sym[5], win_sym[10], win_sym[15]);
            add += xmas_line(win_sym[12], win_sym[9], win_sym[6], win_sym[3]);
        end
        word_sum = (word_sum + add > gwwc_pkg::WORD_MAX) ? gwwc_pkg::WORD_MAX : word_sum + add;
        if (c >= 2 && row_pos >= 2 &&
            mas_diag(win_sym[5], win_sym[10], win_sym[15]) &&
            mas_diag(win_sym[13], win_sym[10], win_sym[7]) &&
            cross_sum < gwwc_pkg::CROSS_MAX)
            cross_sum++;

        if (c + 1 >= w) begin
            col_pos = 0;
            row_slot = (s + 1) % 3;
            if (row_pos < MAX_H - 1) row_pos++;
        end else begin
            col_pos = c + 1;
        end

        done = last;
        tally.words = word_sum[gwwc_pkg::WORD_W-1:0];
        tally.crosses = cross_sum[gwwc_pkg::CROSS_W-1:0];
        if (last) begin
            foreach (win_sym[i]) win_sym[i] = gwwc_pkg::SYM_OTHER;
            col_pos = 0;
            row_pos = 0;
            row_slot = 0;
            word_sum = 0;
            cross_sum = 0;
        end
    endfunction

    function automatic logic [7:0] random_char();
        int unsigned r, k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 3);
        if (r < 75) return WORD_SEQ[8*k +: 8];
        if (r < 88) return CH_DOT;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic [7:0] ch, input logic last, input bit bursty,
                             input bit typed, input t_tally want);
        int unsigned gap;
        t_note note;
        gap = 0;
        if (bursty && !quiet && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 12);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        note.typed = typed;
        note.want = want;
        note_q.push_back(note);
        i_valid <= 1'b1;
        i_ch <= ch;
        i_last <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Write row_width only once the block has drained.
    task automatic set_width(input t_width w);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tally_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        width_cfg = w;
    endtask

    task automatic send_grid(input int unsigned eff, input int unsigned n);
        bit pattern, bursty;
        int unsigned shift, i, k;
        logic [7:0] ch;
        pattern = ($urandom_range(0, 2) == 0);
        shift = $urandom_range(0, 3);
        bursty = ($urandom_range(0, 2) != 0);
        for (i = 0; i < n; i++) begin
            k = ((i % eff) + shift * (i / eff)) % 4;
            ch = (pattern && $urandom_range(0, 9) != 0) ? WORD_SEQ[8*k +: 8] : random_char();
            send_item(ch, i == n - 1, bursty, 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin : accept_track
        t_note  note;
        t_tally tally;
        bit     done;
        if (i_rst_n && i_valid && !o_stall) begin
            note = note_q.pop_front();
            grid_scan_step(i_ch, i_last, done, tally);
            if (done) tally_q.push_back(note.typed ? note.want : tally);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_tally want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (tally_q.size() == 0) begin
                $display("%0t: unexpected result word_count %0d cross_count %0d",
                         $time, o_word_count, o_cross_count);
                err_cnt++;
            end else begin
                want = tally_q.pop_front();
                if (o_word_count !== want.words) begin
                    $display("%0t: word_count expected %0d actual %0d",
                             $time, want.words, o_word_count);
                    err_cnt++;
                end
                if (o_cross_count !== want.crosses) begin
                    $display("%0t: cross_count expected %0d actual %0d",
                             $time, want.crosses, o_cross_count);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : rx_side
        int unsigned burst_left, hold_left, mode_left;
        bit bursty;
        burst_left = 0;
        hold_left = 0;
        mode_left = 0;
        bursty = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
            end
            if (mode_left == 0) begin
                bursty = ($urandom_range(0, 2) != 0);
                mode_left = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_stall <= 1'b1;
            end else if (bursty && !quiet && $urandom_range(0, 9) == 0) begin
                burst_left = $urandom_range(1, 12) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : stim
        int unsigned grid_idx, eff, n, rows;
        t_width nw;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        i_valid <= 1'b0;
        i_ch <= '0;
        i_last <= 1'b0;
        foreach (win_sym[i]) win_sym[i] = gwwc_pkg::SYM_OTHER;
        foreach (prior_rows[i, j]) prior_rows[i][j] = gwwc_pkg::SYM_OTHER;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            if (dir_tab[i].set_w) set_width(dir_tab[i].w);
            send_item(dir_tab[i].ch, dir_tab[i].last, 1'($urandom_range(0, 1)),
                      dir_tab[i].typed, dir_tab[i].want);
        end

        grid_idx = 0;
        while (items_sent < ITEM_GOAL) begin
            if (items_sent >= QUIET_AFTER) quiet = 1'b1;
            if (grid_idx == 3) begin
                // stall the result side and keep offering short grids so the block backs up
                hold_req = 1'b1;
                repeat (8) send_grid(eff_width(width_cfg), 3);
            end else if (grid_idx == 6) begin
                set_width(t_width'($urandom_range(200, 256)));
                eff = eff_width(width_cfg);
                send_grid(eff, eff * 3 + $urandom_range(1, 8));
            end else if (grid_idx == 10) begin
                // grid taller than the row counter can follow
                set_width(t_width'($urandom_range(0, 1)));
                send_grid(1, $urandom_range(258, 300));
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    case ($urandom_range(0, 9))
                        0:       nw = 9'd0;
                        1:       nw = 9'd1;
                        2:       nw = 9'd2;
                        3:       nw = t_width'($urandom_range(0, 511));
                        default: nw = t_width'($urandom_range(3, 12));
                    endcase
                    set_width(nw);
                end
                eff = eff_width(width_cfg);
                if (eff >= 16)      rows = $urandom_range(1, 2);
                else if (eff <= 2)  rows = $urandom_range(4, 30);
                else                rows = $urandom_range(1, 6);
                n = eff * rows;
                if (eff >= 16 || $urandom_range(0, 3) == 0) n = $urandom_range(1, n);
                if (n > GRID_CAP) n = GRID_CAP;
                send_grid(eff, n);
            end
            grid_idx++;
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tally_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/gwwc_pkg.sv
rtl/core/gwwc_line_mem.sv
rtl/core/gwwc_window.sv
rtl/core/grid_word_window_counter_top.sv
sim/grid_word_window_counter_top_tb.sv
